[sv/gds_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and calendar helpers for the Gregorian date stepper.
// Depends on nothing; every other file of the block imports it.
package gds_pkg;

    localparam int AMOUNT_BITS_DEF = 16;
    localparam int YEAR_BITS_DEF   = 14;
    localparam int YEAR_CAP        = 9999;

    // Day additions beyond this span can never land inside the year range.
    localparam int DAY_SPAN_MAX = 3700000;

    // Month arithmetic works on year * 12 + month - 1, which stays below 120000
    // once the range check has passed.
    localparam int TOT_W = 17;
    localparam int Q_W   = TOT_W - 2;

    // Reciprocal of three for the quotient of a value below 2**15.
    localparam int                DIV3_SHIFT = 17;
    localparam logic [Q_W+1:0]    RECIP3     = 17'd43691;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_DAYS   = 2'd1,
        OP_MONTHS = 2'd2,
        OP_YEARS  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_DATE   = 2'd1,
        ST_YEAR_RANGE = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_CAPTURE,
        DP_LOAD_CHK,
        DP_DAY_STEP,
        DP_MON_TOT,
        DP_MON_DIV,
        DP_MON_SPLIT,
        DP_YR_SUM,
        DP_CLAMP,
        DP_COMMIT,
        DP_OUT
    } t_dp_op;

    // Which year feeds the leap-year unit.
    typedef enum logic [1:0] {
        YS_LOAD,
        YS_WORK,
        YS_CUR
    } t_ysel;

    typedef struct packed {
        t_dp_op op;
        t_ysel  ysel;
    } t_dp_cmd;

    typedef struct packed {
        t_op  op;
        logic amt_zero;
        logic cnt_zero;
        logic err;
        logic out_busy;
    } t_dp_stat;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_LOAD_CHK,
        S_DAY_STEP,
        S_MON_TOT,
        S_MON_DIV,
        S_MON_SPLIT,
        S_YR_SUM,
        S_LEAP_W,
        S_CLAMP,
        S_COMMIT,
        S_LEAP_CUR,
        S_OUT
    } t_state;

    localparam logic [4:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    // Length of a month; zero for a month number that means nothing.
    function automatic logic [4:0] month_days(input logic [3:0] m, input logic lp);
        logic [4:0] d;
        d = 5'd0;
        if (m >= 4'd1 && m <= MONTH_DEC) begin
            d = MONTH_LEN[m - 4'd1];
            if (m == MONTH_FEB && lp) begin
                d = 5'd29;
            end
        end
        return d;
    endfunction

    // Inverse of 25 modulo 2**32 by Newton iteration; each pass doubles the
    // number of correct low bits, starting from three.
    function automatic logic [31:0] f_inv25();
        logic [31:0] x;
        x = 32'd1;
        for (int i = 0; i < 5; i++) begin
            x = x * (32'd2 - 32'd25 * x);
        end
        return x;
    endfunction

    localparam logic [31:0] INV25_32 = f_inv25();

endpackage

[sv/gds_leap.sv]
`timescale 1ns / 1ps
// Leap-year test by the 4/100/400 rule for one year value.
// Depends on gds_pkg for the modular inverse of 25.
module gds_leap import gds_pkg::*; #(
    parameter int YEAR_BITS = YEAR_BITS_DEF
) (
    input  logic [YEAR_BITS-1:0] i_year,
    output logic                 o_leap
);

    localparam logic [YEAR_BITS-1:0] INV = INV25_32[YEAR_BITS-1:0];
    localparam logic [YEAR_BITS-1:0] THR = YEAR_BITS'((2**YEAR_BITS - 1) / 25);

    logic [YEAR_BITS-1:0] prod;
    logic                 div25;

    // Multiplying by the inverse of 25 maps the multiples of 25 exactly onto
    // the values no greater than the largest word divided by 25.
    assign prod   = i_year * INV;
    assign div25  = (prod <= THR);
    assign o_leap = (i_year[1:0] == 2'b00) && (!div25 || i_year[3:0] == 4'b0000);

endmodule

[sv/gds_dpath.sv]
`timescale 1ns / 1ps
// Datapath of the date stepper: captured item, current and working date,
// day counter, month split and output register. Depends on gds_pkg, gds_leap.
module gds_dpath import gds_pkg::*; #(
    parameter int AMOUNT_BITS = AMOUNT_BITS_DEF,
    parameter int YEAR_BITS   = YEAR_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_dp_cmd                       i_cmd,
    output t_dp_stat                      o_stat,
    input  logic [1:0]                    i_op,
    input  logic signed [AMOUNT_BITS-1:0] i_amount,
    input  logic [4:0]                    i_load_day,
    input  logic [3:0]                    i_load_month,
    input  logic [YEAR_BITS-1:0]          i_load_year,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [4:0]                    o_day,
    output logic [3:0]                    o_month,
    output logic [YEAR_BITS-1:0]          o_year,
    output logic                          o_leap_year,
    output logic [1:0]                    o_status
);

    localparam int YEAR_MAX = 2**YEAR_BITS - 1;
    localparam int YEAR_LIM = (YEAR_MAX > YEAR_CAP) ? YEAR_CAP : YEAR_MAX;
    localparam int SW = ((YEAR_BITS + 4 > AMOUNT_BITS) ? YEAR_BITS + 4 : AMOUNT_BITS) + 2;
    localparam int YW = ((YEAR_BITS > AMOUNT_BITS) ? YEAR_BITS : AMOUNT_BITS) + 2;

    localparam logic [YEAR_BITS-1:0] YEAR_LIM_V = YEAR_BITS'(YEAR_LIM);
    localparam logic signed [SW-1:0] TOT_LO     = SW'(12);
    localparam logic signed [SW-1:0] TOT_HI     = SW'(12 * (YEAR_LIM + 1));
    localparam logic signed [YW-1:0] YS_LO      = YW'(1);
    localparam logic signed [YW-1:0] YS_HI      = YW'(YEAR_LIM);

    // Captured item
    t_op                      r_op;
    logic [AMOUNT_BITS-1:0]   r_amt;
    logic [4:0]               r_ld_day;
    logic [3:0]               r_ld_month;
    logic [YEAR_BITS-1:0]     r_ld_year;
    // Current and working date
    logic [4:0]               r_day,  r_wd;
    logic [3:0]               r_month, r_wm;
    logic [YEAR_BITS-1:0]     r_year, r_wy;
    // Day stepping and month split
    logic [AMOUNT_BITS-1:0]   r_cnt;
    logic                     r_back;
    logic [TOT_W-1:0]         r_tot;
    logic [Q_W-1:0]           r_q;
    t_status                  r_status;
    logic                     r_leap;
    // Output register
    logic                     r_out_valid;
    logic [4:0]               r_o_day;
    logic [3:0]               r_o_month;
    logic [YEAR_BITS-1:0]     r_o_year;
    logic                     r_o_leap;
    t_status                  r_o_status;

    logic [YEAR_BITS-1:0]     leap_in;
    logic                     leap_out;
    logic [AMOUNT_BITS-1:0]   amt_u;
    logic [AMOUNT_BITS-1:0]   amt_abs;
    logic signed [33:0]       amt_x;
    logic                     too_far;
    logic [4:0]               md_w, md_prev, md_ld;
    logic signed [SW-1:0]     y_s, tot;
    logic [Q_W-1:0]           tot_x;
    logic [31:0]              q_prod;
    logic [Q_W-1:0]           rem3;
    logic signed [YW-1:0]     ys;
    logic                     ld_ok;

    always_comb begin
        case (i_cmd.ysel)
            YS_LOAD: leap_in = r_ld_year;
            YS_CUR:  leap_in = r_year;
            default: leap_in = r_wy;
        endcase
    end

    gds_leap #(.YEAR_BITS(YEAR_BITS)) u_leap (
        .i_year (leap_in),
        .o_leap (leap_out)
    );

    assign amt_u   = i_amount;
    assign amt_abs = i_amount[AMOUNT_BITS-1] ? (~amt_u + AMOUNT_BITS'(1)) : amt_u;
    assign amt_x   = $signed({{(34-AMOUNT_BITS){i_amount[AMOUNT_BITS-1]}}, amt_u});
    assign too_far = (amt_x > 34'(DAY_SPAN_MAX)) || (amt_x < -34'(DAY_SPAN_MAX));

    assign md_w    = month_days(r_wm, r_leap);
    assign md_prev = month_days(r_wm - 4'd1, r_leap);
    assign md_ld   = month_days(r_ld_month, r_leap);

    // Month count since year zero, then the amount on top.
    assign y_s   = $signed({{(SW-YEAR_BITS){1'b0}}, r_year});
    assign tot   = (y_s <<< 3) + (y_s <<< 2)
                 + $signed({{(SW-4){1'b0}}, r_month}) - SW'(1)
                 + $signed({{(SW-AMOUNT_BITS){r_amt[AMOUNT_BITS-1]}}, r_amt});

    // Division by 12 is a shift by two and a reciprocal multiply by three.
    assign tot_x  = r_tot[TOT_W-1:2];
    assign q_prod = 32'(tot_x) * 32'(RECIP3);
    assign rem3   = tot_x - (r_q << 1) - r_q;

    assign ys = $signed({{(YW-YEAR_BITS){1'b0}}, r_year})
              + $signed({{(YW-AMOUNT_BITS){r_amt[AMOUNT_BITS-1]}}, r_amt});

    assign ld_ok = (r_ld_month inside {[4'd1:4'd12]})
                && (r_ld_year != '0) && (r_ld_year <= YEAR_LIM_V)
                && (r_ld_day != 5'd0) && (r_ld_day <= md_ld);

    always_ff @(posedge i_clk) begin
        r_leap <= leap_out;
        if (!i_rst_n) begin
            r_day       <= 5'd1;
            r_month     <= 4'd1;
            r_year      <= YEAR_BITS'(2000);
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && i_cmd.op != DP_OUT) begin
                r_out_valid <= 1'b0;
            end
            case (i_cmd.op)
                DP_CAPTURE: begin
                    r_op       <= t_op'(i_op);
                    r_amt      <= amt_u;
                    r_ld_day   <= i_load_day;
                    r_ld_month <= i_load_month;
                    r_ld_year  <= i_load_year;
                    r_cnt      <= amt_abs;
                    r_back     <= i_amount[AMOUNT_BITS-1];
                    r_wd       <= r_day;
                    r_wm       <= r_month;
                    r_wy       <= r_year;
                    r_status   <= (t_op'(i_op) == OP_DAYS && too_far) ? ST_YEAR_RANGE : ST_OK;
                end
                DP_LOAD_CHK: begin
                    if (ld_ok) begin
                        r_wd <= r_ld_day;
                        r_wm <= r_ld_month;
                        r_wy <= r_ld_year;
                    end else begin
                        r_status <= ST_BAD_DATE;
                    end
                end
                DP_DAY_STEP: begin
                    r_cnt <= r_cnt - AMOUNT_BITS'(1);
                    if (!r_back) begin
                        if (r_wd < md_w) begin
                            r_wd <= r_wd + 5'd1;
                        end else begin
                            r_wd <= 5'd1;
                            if (r_wm == MONTH_DEC) begin
                                r_wm <= 4'd1;
                                if (r_wy == YEAR_LIM_V) begin
                                    r_status <= ST_YEAR_RANGE;
                                end else begin
                                    r_wy <= r_wy + YEAR_BITS'(1);
                                end
                            end else begin
                                r_wm <= r_wm + 4'd1;
                            end
                        end
                    end else begin
                        if (r_wd <= 5'd1) begin
                            if (r_wm == 4'd1) begin
                                r_wm <= MONTH_DEC;
                                r_wd <= 5'd31;
                                if (r_wy == YEAR_BITS'(1)) begin
                                    r_status <= ST_YEAR_RANGE;
                                end else begin
                                    r_wy <= r_wy - YEAR_BITS'(1);
                                end
                            end else begin
                                r_wm <= r_wm - 4'd1;
                                r_wd <= md_prev;
                            end
                        end else begin
                            r_wd <= r_wd - 5'd1;
                        end
                    end
                end
                DP_MON_TOT: begin
                    r_tot <= tot[TOT_W-1:0];
                    if (tot < TOT_LO || tot >= TOT_HI) begin
                        r_status <= ST_YEAR_RANGE;
                    end
                end
                DP_MON_DIV: begin
                    r_q <= q_prod[DIV3_SHIFT+Q_W-1:DIV3_SHIFT];
                end
                DP_MON_SPLIT: begin
                    r_wm <= {rem3[1:0], r_tot[1:0]} + 4'd1;
                    r_wy <= YEAR_BITS'(r_q);
                end
                DP_YR_SUM: begin
                    r_wy <= ys[YEAR_BITS-1:0];
                    if (ys < YS_LO || ys > YS_HI) begin
                        r_status <= ST_YEAR_RANGE;
                    end
                end
                DP_CLAMP: begin
                    if (r_wd > md_w) begin
                        r_wd <= md_w;
                    end
                end
                DP_COMMIT: begin
                    if (r_status == ST_OK) begin
                        r_day   <= r_wd;
                        r_month <= r_wm;
                        r_year  <= r_wy;
                    end
                end
                DP_OUT: begin
                    r_out_valid <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == DP_OUT) begin
            r_o_day    <= r_day;
            r_o_month  <= r_month;
            r_o_year   <= r_year;
            r_o_leap   <= r_leap;
            r_o_status <= r_status;
        end
    end

    assign o_stat.op       = r_op;
    assign o_stat.amt_zero = (r_amt == '0);
    assign o_stat.cnt_zero = (r_cnt == '0);
    assign o_stat.err      = (r_status != ST_OK);
    assign o_stat.out_busy = r_out_valid && !i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_day       = r_o_day;
    assign o_month     = r_o_month;
    assign o_year      = r_o_year;
    assign o_leap_year = r_o_leap;
    assign o_status    = r_o_status;

endmodule

[sv/gds_ctrl.sv]
`timescale 1ns / 1ps
// Sequencing state machine of the date stepper: issues one datapath command
// per cycle from the captured operation. Depends on gds_pkg.
module gds_ctrl import gds_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd.op   = DP_NOP;
        o_cmd.ysel = YS_WORK;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = DP_CAPTURE;
                    n_state  = S_PREP;
                end
            end
            S_PREP: begin
                if (i_stat.op == OP_LOAD) begin
                    o_cmd.ysel = YS_LOAD;
                    n_state    = S_LOAD_CHK;
                end else if (i_stat.amt_zero) begin
                    n_state = S_COMMIT;
                end else begin
                    case (i_stat.op)
                        OP_DAYS:   n_state = S_DAY_STEP;
                        OP_MONTHS: n_state = S_MON_TOT;
                        default:   n_state = S_YR_SUM;
                    endcase
                end
            end
            S_LOAD_CHK: begin
                o_cmd.op = DP_LOAD_CHK;
                n_state  = S_COMMIT;
            end
            S_DAY_STEP: begin
                if (i_stat.cnt_zero || i_stat.err) begin
                    n_state = S_COMMIT;
                end else begin
                    o_cmd.op = DP_DAY_STEP;
                end
            end
            S_MON_TOT: begin
                o_cmd.op = DP_MON_TOT;
                n_state  = S_MON_DIV;
            end
            S_MON_DIV: begin
                o_cmd.op = DP_MON_DIV;
                n_state  = S_MON_SPLIT;
            end
            S_MON_SPLIT: begin
                o_cmd.op = DP_MON_SPLIT;
                n_state  = S_LEAP_W;
            end
            S_YR_SUM: begin
                o_cmd.op = DP_YR_SUM;
                n_state  = S_LEAP_W;
            end
            S_LEAP_W: begin
                n_state = S_CLAMP;
            end
            S_CLAMP: begin
                o_cmd.op = DP_CLAMP;
                n_state  = S_COMMIT;
            end
            S_COMMIT: begin
                o_cmd.op = DP_COMMIT;
                n_state  = S_LEAP_CUR;
            end
            S_LEAP_CUR: begin
                o_cmd.ysel = YS_CUR;
                n_state    = S_OUT;
            end
            S_OUT: begin
                o_cmd.ysel = YS_CUR;
                if (!i_stat.out_busy) begin
                    o_cmd.op = DP_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[sv/gregorian_date_stepper_core.sv]
`timescale 1ns / 1ps
// Gregorian date stepper: holds one date (1 January 2000 after reset) and
// takes one command per transfer: load, add days, add months or add years.
// Each item gives one result with the date, its leap flag and a status. Items
// are handled one at a time; the day loop advances the date by one day per
// clock until its count runs out or the year leaves the range. A zero amount
// skips straight to the commit. The next item is taken while a result waits.
// Depends on gds_pkg, gds_ctrl and gds_dpath.
module gregorian_date_stepper_core import gds_pkg::*; #(
    parameter int AMOUNT_BITS = AMOUNT_BITS_DEF,
    parameter int YEAR_BITS   = YEAR_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_op,
    input  logic signed [AMOUNT_BITS-1:0] i_amount,
    input  logic [4:0]                    i_load_day,
    input  logic [3:0]                    i_load_month,
    input  logic [YEAR_BITS-1:0]          i_load_year,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [4:0]                    o_day,
    output logic [3:0]                    o_month,
    output logic [YEAR_BITS-1:0]          o_year,
    output logic                          o_leap_year,
    output logic [1:0]                    o_status
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    gds_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    gds_dpath #(
        .AMOUNT_BITS (AMOUNT_BITS),
        .YEAR_BITS   (YEAR_BITS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_stat       (dp_stat),
        .i_op         (i_op),
        .i_amount     (i_amount),
        .i_load_day   (i_load_day),
        .i_load_month (i_load_month),
        .i_load_year  (i_load_year),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_day        (o_day),
        .o_month      (o_month),
        .o_year       (o_year),
        .o_leap_year  (o_leap_year),
        .o_status     (o_status)
    );

endmodule

[sv/gds_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the date stepper, bound onto the top level.
// Depends on gds_pkg and gregorian_date_stepper_core.
module gds_checker import gds_pkg::*; #(
    parameter int AMOUNT_BITS = AMOUNT_BITS_DEF,
    parameter int YEAR_BITS   = YEAR_BITS_DEF
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic [1:0]                    i_op,
    input logic signed [AMOUNT_BITS-1:0] i_amount,
    input logic [4:0]                    i_load_day,
    input logic [3:0]                    i_load_month,
    input logic [YEAR_BITS-1:0]          i_load_year,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [4:0]                    o_day,
    input logic [3:0]                    o_month,
    input logic [YEAR_BITS-1:0]          o_year,
    input logic                          o_leap_year,
    input logic [1:0]                    o_status
);

    // Only one item is in work, so the input closes straight after a transfer.
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input still open after a transfer");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_day)
            && $stable(o_month) && $stable(o_year) && $stable(o_status))
        else $error("stalled result changed");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ST_OK || o_status == ST_BAD_DATE
            || o_status == ST_YEAR_RANGE))
        else $error("undefined status code");

    // The held date is always a real date, whatever the command did.
    a_date_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_month >= 4'd1 && o_month <= 4'd12 && o_day != 5'd0
            && o_day <= month_days(o_month, o_leap_year) && o_year != '0)
        else $error("result date out of range");

endmodule

bind gregorian_date_stepper_core gds_checker #(
    .AMOUNT_BITS (AMOUNT_BITS),
    .YEAR_BITS   (YEAR_BITS)
) u_gds_checker (.*);

[tb/tb_gregorian_date_stepper_core.sv]
`timescale 1ns / 1ps
// Self-checking testbench for gregorian_date_stepper_core: directed and random
// date commands are checked against a calendar predictor kept in the bench.
// Depends on gds_pkg and the core with its submodules.
module tb_gregorian_date_stepper_core;
    import gds_pkg::*;

    localparam int AMT_W       = AMOUNT_BITS_DEF;
    localparam int YR_W        = YEAR_BITS_DEF;
    localparam int STALL_LIMIT = 150000;
    localparam int TAIL_CYCLES = 40;
    localparam int HOLD_CYCLES = 400;
    localparam int MAX_REPORTS = 200;
    localparam int DAYS_OF_MONTH [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    typedef struct {
        logic [4:0]      day;
        logic [3:0]      month;
        logic [YR_W-1:0] year;
        logic            leap;
        t_status         status;
    } t_date_result;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_ready;
    logic [1:0]              i_op;
    logic signed [AMT_W-1:0] i_amount;
    logic [4:0]              i_load_day;
    logic [3:0]              i_load_month;
    logic [YR_W-1:0]         i_load_year;
    logic                    o_out_valid;
    logic                    i_out_ready;
    logic [4:0]              o_day;
    logic [3:0]              o_month;
    logic [YR_W-1:0]         o_year;
    logic                    o_leap_year;
    logic [1:0]              o_status;

    t_date_result pending_dates [$];
    int cal_day;
    int cal_month;
    int cal_year;
    int year_max;
    int mismatches;
    int results_seen;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_request;
    int big_day_adds;

    gregorian_date_stepper_core #(
        .AMOUNT_BITS(AMT_W),
        .YEAR_BITS  (YR_W)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_op        (i_op),
        .i_amount    (i_amount),
        .i_load_day  (i_load_day),
        .i_load_month(i_load_month),
        .i_load_year (i_load_year),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_day       (o_day),
        .o_month     (o_month),
        .o_year      (o_year),
        .o_leap_year (o_leap_year),
        .o_status    (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic bit is_leap(int y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int days_in(int m, int y);
        if (m < 1 || m > 12) begin
            return 0;
        end
        if (m == 2 && is_leap(y)) begin
            return 29;
        end
        return DAYS_OF_MONTH[m-1];
    endfunction

    // Works out the date after one accepted command and queues the result.
    task automatic predict_date(input t_op op, input int amt, input int ld, input int lm,
                                input int ly);
        t_date_result r;
        int d;
        int m;
        int y;
        int n;
        int tot;
        t_status st;
        st = ST_OK;
        case (op)
            OP_LOAD: begin
                if (lm < 1 || lm > 12 || ly < 1 || ly > year_max || ld < 1 ||
                    ld > days_in(lm, ly)) begin
                    st = ST_BAD_DATE;
                end else begin
                    cal_day   = ld;
                    cal_month = lm;
                    cal_year  = ly;
                end
            end
            OP_DAYS: begin
                d = cal_day;
                m = cal_month;
                y = cal_year;
                n = amt;
                while (n != 0 && st == ST_OK) begin
                    if (n > 0) begin
                        if (d < days_in(m, y)) begin
                            d++;
                        end else begin
                            d = 1;
                            m++;
                            if (m > 12) begin
                                m = 1;
                                y++;
                            end
                        end
                        n--;
                    end else begin
                        if (d <= 1) begin
                            m--;
                            if (m < 1) begin
                                m = 12;
                                y--;
                            end
                            d = days_in(m, y);
                        end else begin
                            d--;
                        end
                        n++;
                    end
                    if (y < 1 || y > year_max) begin
                        st = ST_YEAR_RANGE;
                    end
                end
                if (st == ST_OK) begin
                    cal_day   = d;
                    cal_month = m;
                    cal_year  = y;
                end
            end
            OP_MONTHS: begin
                if (amt != 0) begin
                    tot = cal_year * 12 + cal_month - 1 + amt;
                    if (tot < 12) begin
                        st = ST_YEAR_RANGE;
                    end else begin
                        y = tot / 12;
                        m = tot % 12 + 1;
                        if (y > year_max) begin
                            st = ST_YEAR_RANGE;
                        end else begin
                            if (cal_day > days_in(m, y)) begin
                                cal_day = days_in(m, y);
                            end
                            cal_month = m;
                            cal_year  = y;
                        end
                    end
                end
            end
            OP_YEARS: begin
                if (amt != 0) begin
                    y = cal_year + amt;
                    if (y < 1 || y > year_max) begin
                        st = ST_YEAR_RANGE;
                    end else begin
                        if (cal_month == 2 && cal_day == 29 && !is_leap(y)) begin
                            cal_day = 28;
                        end
                        cal_year = y;
                    end
                end
            end
            default: begin
            end
        endcase
        r.day    = 5'(cal_day);
        r.month  = 4'(cal_month);
        r.year   = YR_W'(cal_year);
        r.leap   = is_leap(cal_year);
        r.status = st;
        pending_dates.push_back(r);
    endtask

    task automatic report_mismatch(input string field, input int got, input int want);
        if (mismatches < MAX_REPORTS) begin
            $display("%0t: result %0d, %s: got %0d, wanted %0d", $realtime, results_seen,
                     field, got, want);
        end
        mismatches++;
    endtask

    // Offers one command, holding it until the transfer, then predicts it.
    task automatic send_cmd(input t_op op, input int amt, input int ld, input int lm,
                            input int ly);
        logic signed [AMT_W-1:0] a_bits;
        logic [4:0]              d_bits;
        logic [3:0]              m_bits;
        logic [YR_W-1:0]         y_bits;
        a_bits = AMT_W'(amt);
        d_bits = 5'(ld);
        m_bits = 4'(lm);
        y_bits = YR_W'(ly);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid   <= 1'b1;
        i_op         <= op;
        i_amount     <= a_bits;
        i_load_day   <= d_bits;
        i_load_month <= m_bits;
        i_load_year  <= y_bits;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        predict_date(op, int'(a_bits), int'(d_bits), int'(m_bits), int'(y_bits));
    endtask

    task automatic wait_all_results();
        i_in_valid <= 1'b0;
        while (pending_dates.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic pick_valid_date(output int ld, output int lm, output int ly);
        case ($urandom_range(3))
            0:       ly = $urandom_range(1, 3);
            1:       ly = $urandom_range(year_max - 2, year_max);
            default: ly = $urandom_range(1, year_max);
        endcase
        lm = $urandom_range(1, 12);
        if ($urandom_range(2) == 0) begin
            ld = days_in(lm, ly);
        end else begin
            ld = $urandom_range(1, days_in(lm, ly));
        end
    endtask

    task automatic send_random_cmd();
        int sel;
        int amt;
        int ld;
        int lm;
        int ly;
        t_op op;
        sel = $urandom_range(99);
        ld  = $urandom_range(31);
        lm  = $urandom_range(15);
        ly  = $urandom_range((1 << YR_W) - 1);
        amt = $urandom_range(65535) - 32768;
        if (sel < 15) begin
            op = OP_LOAD;
            if ($urandom_range(9) < 7) begin
                pick_valid_date(ld, lm, ly);
            end
        end else if (sel < 50) begin
            op = OP_DAYS;
            // Long day walks keep the core busy the longest, so at most three are allowed.
            if (big_day_adds < 3 && $urandom_range(29) == 0) begin
                big_day_adds++;
            end else begin
                amt = $urandom_range(3000) - 1500;
            end
        end else begin
            if (sel < 75) begin
                op = OP_MONTHS;
            end else begin
                op = OP_YEARS;
            end
            if ($urandom_range(1) == 0) begin
                amt = $urandom_range(60) - 30;
            end
        end
        send_cmd(op, amt, ld, lm, ly);
    endtask

    task automatic test_loads();
        send_cmd(OP_LOAD, 0, 29, 2, 2000);
        send_cmd(OP_LOAD, 0, 29, 2, 1900);
        send_cmd(OP_LOAD, -1, 31, 4, 2021);
        send_cmd(OP_LOAD, 0, 15, 0, 2021);
        send_cmd(OP_LOAD, 0, 1, 13, 2021);
        send_cmd(OP_LOAD, 0, 0, 6, 2021);
        send_cmd(OP_LOAD, 0, 1, 1, 0);
        send_cmd(OP_LOAD, 0, 31, 15, (1 << YR_W) - 1);
        send_cmd(OP_LOAD, 0, 1, 1, 10000);
        wait_all_results();
    endtask

    task automatic test_day_steps();
        send_cmd(OP_LOAD, 0, 1, 1, 1);
        send_cmd(OP_DAYS, -1, 0, 0, 0);
        send_cmd(OP_DAYS, 0, 0, 0, 0);
        send_cmd(OP_LOAD, 0, 31, 12, 9999);
        send_cmd(OP_DAYS, 1, 0, 0, 0);
        send_cmd(OP_LOAD, 0, 28, 2, 2024);
        send_cmd(OP_DAYS, 1, 0, 0, 0);
        send_cmd(OP_DAYS, 32767, 0, 0, 0);
        send_cmd(OP_DAYS, -32768, 0, 0, 0);
        wait_all_results();
    endtask

    task automatic test_month_steps();
        send_cmd(OP_LOAD, 0, 31, 1, 2023);
        send_cmd(OP_MONTHS, 1, 0, 0, 0);
        // February plus ten months lands on December, where a plain modulo gives zero.
        send_cmd(OP_MONTHS, 10, 0, 0, 0);
        send_cmd(OP_MONTHS, -32768, 0, 0, 0);
        send_cmd(OP_MONTHS, 32767, 0, 0, 0);
        wait_all_results();
    endtask

    task automatic test_year_steps();
        send_cmd(OP_LOAD, 0, 29, 2, 2024);
        send_cmd(OP_YEARS, 1, 0, 0, 0);
        send_cmd(OP_YEARS, 0, 0, 0, 0);
        send_cmd(OP_YEARS, 32767, 0, 0, 0);
        send_cmd(OP_YEARS, -32768, 0, 0, 0);
        wait_all_results();
    endtask

    task automatic test_random_cmds(input int count, input int s_idle, input int r_idle);
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        for (int i = 0; i < count; i++) begin
            send_random_cmd();
        end
        // The sender pauses here until every outstanding result has come back.
        wait_all_results();
    endtask

    // The receiver holds off while commands keep coming, so the core fills and
    // stops taking transfers until the hold is released.
    task automatic test_output_hold();
        int ld;
        int lm;
        int ly;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = HOLD_CYCLES;
        for (int i = 0; i < 10; i++) begin
            if (i % 2 == 0) begin
                pick_valid_date(ld, lm, ly);
                send_cmd(OP_LOAD, 0, ld, lm, ly);
            end else begin
                send_cmd(OP_YEARS, $urandom_range(20) - 10, 0, 0, 0);
            end
        end
        wait_all_results();
    endtask

    initial begin : receiver
        int hold_left;
        hold_left = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_date_result want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_ready === 1'b1) begin
            if (pending_dates.size() == 0) begin
                report_mismatch("unexpected result, day", o_day, 0);
            end else begin
                want = pending_dates.pop_front();
                if (o_day !== want.day) begin
                    report_mismatch("day", o_day, want.day);
                end
                if (o_month !== want.month) begin
                    report_mismatch("month", o_month, want.month);
                end
                if (o_year !== want.year) begin
                    report_mismatch("year", o_year, want.year);
                end
                if (o_leap_year !== want.leap) begin
                    report_mismatch("leap_year", o_leap_year, want.leap);
                end
                if (o_status !== want.status) begin
                    report_mismatch("status", o_status, want.status);
                end
            end
            results_seen++;
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if (i_rst_n !== 1'b1 || (i_in_valid === 1'b1 && o_in_ready === 1'b1) ||
                (o_out_valid === 1'b1 && i_out_ready === 1'b1)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_op          <= OP_LOAD;
        i_amount      <= '0;
        i_load_day    <= '0;
        i_load_month  <= '0;
        i_load_year   <= '0;
        cal_day       = 1;
        cal_month     = 1;
        cal_year      = 2000;
        year_max      = ((1 << YR_W) - 1 > YEAR_CAP) ? YEAR_CAP : (1 << YR_W) - 1;
        mismatches    = 0;
        results_seen  = 0;
        hold_request  = 0;
        big_day_adds  = 0;
        send_idle_pct = 20;
        recv_idle_pct = 87;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_loads();
        test_day_steps();
        test_month_steps();
        test_year_steps();
        test_random_cmds(24, 20, 87);
        test_random_cmds(23, 87, 20);
        test_random_cmds(23, 0, 0);
        test_output_hold();

        wait_all_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[filelist.f]
sv/gds_pkg.sv
sv/gds_leap.sv
sv/gds_dpath.sv
sv/gds_ctrl.sv
sv/gregorian_date_stepper_core.sv
sv/gds_checker.sv
tb/tb_gregorian_date_stepper_core.sv
